FILE: rtl/rvx_pkg.sv
// Package for the RV32 subset execute unit: codes, sizes, decoded item type.
// No dependencies; imported by every other file in rtl/.
package rvx_pkg;

    localparam int DATA_DEPTH  = 1024;   // data memory words (power of two)
    localparam int PROG_DEPTH  = 1024;   // program index space (power of two)
    localparam int QUEUE_DEPTH = 2;      // front-to-back queue entries (power of two)

    localparam int DA_W      = $clog2(DATA_DEPTH);
    localparam int PC_W      = $clog2(PROG_DEPTH);
    localparam int NEXT_PC_W = 10;
    localparam int TGT_W     = 10;
    localparam int REG_W     = 5;
    localparam int XLEN      = 32;

    typedef enum logic [4:0] {
        KIND_ADD   = 5'd0,
        KIND_SUB   = 5'd1,
        KIND_SLT   = 5'd2,
        KIND_AND   = 5'd3,
        KIND_OR    = 5'd4,
        KIND_XOR   = 5'd5,
        KIND_SLL   = 5'd6,
        KIND_SRL   = 5'd7,
        KIND_ADDI  = 5'd8,
        KIND_SLTI  = 5'd9,
        KIND_ANDI  = 5'd10,
        KIND_ORI   = 5'd11,
        KIND_XORI  = 5'd12,
        KIND_JALR  = 5'd13,
        KIND_BEQ   = 5'd14,
        KIND_BNE   = 5'd15,
        KIND_BLT   = 5'd16,
        KIND_BGE   = 5'd17,
        KIND_BLE   = 5'd18,
        KIND_J     = 5'd19,
        KIND_JAL   = 5'd20,
        KIND_LI    = 5'd21,
        KIND_LOAD  = 5'd22,
        KIND_STORE = 5'd23,
        KIND_EXIT  = 5'd24
    } kind_t;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_ALU,
        CLS_JALR,
        CLS_BRANCH,
        CLS_JAL,
        CLS_LI,
        CLS_LOAD,
        CLS_STORE,
        CLS_EXIT
    } ex_class_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLT,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_SLL,
        ALU_SRL
    } alu_op_t;

    typedef enum logic [2:0] {
        BR_EQ,
        BR_NE,
        BR_LT,
        BR_GE,
        BR_LE,
        BR_ALWAYS
    } br_cond_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_READ,
        BK_EXEC,
        BK_LOAD
    } bk_state_t;

    typedef struct packed {
        ex_class_t           cls;
        alu_op_t             alu;
        logic                use_imm;
        br_cond_t            cond;
        logic [REG_W-1:0]    rd;
        logic [REG_W-1:0]    rs1;
        logic [REG_W-1:0]    rs2;
        logic [XLEN-1:0]     imm;
        logic [TGT_W-1:0]    tgt;
        logic                known;
        logic                rel;
    } rvx_item_t;

endpackage

FILE: rtl/rvx_front.sv
// Front end: takes input items and classifies them into a decoded item.
// Depends on rvx_pkg.
module rvx_front (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [4:0]                s_kind,
    input  logic [4:0]                s_dest_reg,
    input  logic [4:0]                s_src1_reg,
    input  logic [4:0]                s_src2_reg,
    input  logic signed [31:0]        s_immediate,
    input  logic [9:0]                s_target_pc,
    input  logic                      s_target_known,
    input  logic                      s_jump_relative,
    input  logic                      q_full,
    input  logic                      clearing,
    output logic                      q_push,
    output rvx_pkg::rvx_item_t        q_item
);
    import rvx_pkg::*;

    assign s_ready = !q_full && !clearing;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_item         = '0;
        q_item.cls     = CLS_NOP;
        q_item.alu     = ALU_ADD;
        q_item.cond    = BR_ALWAYS;
        q_item.use_imm = 1'b0;
        q_item.rd      = s_dest_reg;
        q_item.rs1     = s_src1_reg;
        q_item.rs2     = s_src2_reg;
        q_item.imm     = $unsigned(s_immediate);
        q_item.tgt     = s_target_pc;
        q_item.known   = s_target_known;
        q_item.rel     = s_jump_relative;
        case (s_kind)
            KIND_ADD:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_ADD; end
            KIND_SUB:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_SUB; end
            KIND_SLT:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_SLT; end
            KIND_AND:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_AND; end
            KIND_OR:    begin q_item.cls = CLS_ALU; q_item.alu = ALU_OR;  end
            KIND_XOR:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_XOR; end
            KIND_SLL:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_SLL; end
            KIND_SRL:   begin q_item.cls = CLS_ALU; q_item.alu = ALU_SRL; end
            KIND_ADDI:  begin
                q_item.cls = CLS_ALU; q_item.alu = ALU_ADD; q_item.use_imm = 1'b1;
            end
            KIND_SLTI:  begin
                q_item.cls = CLS_ALU; q_item.alu = ALU_SLT; q_item.use_imm = 1'b1;
            end
            KIND_ANDI:  begin
                q_item.cls = CLS_ALU; q_item.alu = ALU_AND; q_item.use_imm = 1'b1;
            end
            KIND_ORI:   begin
                q_item.cls = CLS_ALU; q_item.alu = ALU_OR; q_item.use_imm = 1'b1;
            end
            KIND_XORI:  begin
                q_item.cls = CLS_ALU; q_item.alu = ALU_XOR; q_item.use_imm = 1'b1;
            end
            KIND_JALR:  q_item.cls = CLS_JALR;
            KIND_BEQ:   begin q_item.cls = CLS_BRANCH; q_item.cond = BR_EQ; end
            KIND_BNE:   begin q_item.cls = CLS_BRANCH; q_item.cond = BR_NE; end
            KIND_BLT:   begin q_item.cls = CLS_BRANCH; q_item.cond = BR_LT; end
            KIND_BGE:   begin q_item.cls = CLS_BRANCH; q_item.cond = BR_GE; end
            KIND_BLE:   begin q_item.cls = CLS_BRANCH; q_item.cond = BR_LE; end
            KIND_J:     begin q_item.cls = CLS_BRANCH; q_item.cond = BR_ALWAYS; end
            KIND_JAL:   q_item.cls = CLS_JAL;
            KIND_LI:    q_item.cls = CLS_LI;
            KIND_LOAD:  q_item.cls = CLS_LOAD;
            KIND_STORE: q_item.cls = CLS_STORE;
            KIND_EXIT:  q_item.cls = CLS_EXIT;
            default:    q_item.cls = CLS_NOP;   // unused codes just advance pc
        endcase
    end

endmodule

FILE: rtl/rvx_queue.sv
// Short FIFO of decoded items between front and back end.
// Depends on rvx_pkg.
module rvx_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rvx_pkg::rvx_item_t  push_item,
    input  logic                pop,
    output rvx_pkg::rvx_item_t  head_item,
    output logic                full,
    output logic                empty
);
    import rvx_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    rvx_item_t         entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QC_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QC_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

FILE: rtl/rvx_back.sv
// Back end: register file, data memory, pc/halt state, execute FSM, result register.
// Depends on rvx_pkg.
module rvx_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  rvx_pkg::rvx_item_t  head_item,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                clearing,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_next_pc,
    output logic                m_reg_written,
    output logic [4:0]          m_written_reg,
    output logic signed [31:0]  m_written_value,
    output logic                m_error,
    output logic                m_halted
);
    import rvx_pkg::*;

    bk_state_t          state_reg, state_next;
    rvx_item_t          cur_reg;
    logic [PC_W-1:0]    pc_reg;
    logic               halt_reg;

    // register file: two registered read ports, one write port, valid bits for reset
    logic [XLEN-1:0]    rf_mem [32];
    logic [31:0]        rf_vld_reg;
    logic [XLEN-1:0]    rf_a_reg, rf_b_reg;
    logic               rf_a_vld_reg, rf_b_vld_reg;

    // data memory, cleared by a sweep after reset
    logic [XLEN-1:0]    dmem [DATA_DEPTH];
    logic [XLEN-1:0]    mem_rdata_reg;
    logic [DA_W-1:0]    clr_idx_reg;

    // result register
    logic               out_valid_reg;
    logic [NEXT_PC_W-1:0] out_npc_reg;
    logic               out_wr_reg;
    logic [REG_W-1:0]   out_rd_reg;
    logic [XLEN-1:0]    out_val_reg;
    logic               out_err_reg;
    logic               out_halt_reg;

    // control
    logic               out_free, finish, mem_rd_en, mem_wr_en, clear_wr, clear_last;

    // datapath
    logic [XLEN-1:0]    a, b, opnd2, alu_res, link, ld_addr, st_addr, mem_addr, rel_tgt;
    logic               addr_oob, taken;
    logic [PC_W-1:0]    pc_inc;
    logic [PC_W-1:0]    res_npc;
    logic               res_wr, res_err, res_halt;
    logic [XLEN-1:0]    res_val;

    assign out_free   = !out_valid_reg || m_ready;
    assign clearing   = (state_reg == BK_CLEAR);
    assign clear_last = (clr_idx_reg == DA_W'(DATA_DEPTH - 1));

    assign a        = rf_a_vld_reg ? rf_a_reg : '0;
    assign b        = rf_b_vld_reg ? rf_b_reg : '0;
    assign opnd2    = cur_reg.use_imm ? cur_reg.imm : b;
    assign link     = XLEN'(pc_reg) + XLEN'(1);
    assign pc_inc   = link[PC_W-1:0];
    assign rel_tgt  = XLEN'(pc_reg) + cur_reg.imm;
    assign ld_addr  = a + cur_reg.imm;
    assign st_addr  = b + cur_reg.imm;
    assign mem_addr = (cur_reg.cls == CLS_STORE) ? st_addr : ld_addr;
    assign addr_oob = (mem_addr >= XLEN'(DATA_DEPTH));

    always_comb begin
        case (cur_reg.alu)
            ALU_ADD: alu_res = a + opnd2;
            ALU_SUB: alu_res = a - opnd2;
            ALU_SLT: alu_res = XLEN'($signed(a) < $signed(opnd2));
            ALU_AND: alu_res = a & opnd2;
            ALU_OR:  alu_res = a | opnd2;
            ALU_XOR: alu_res = a ^ opnd2;
            ALU_SLL: alu_res = a << opnd2[4:0];
            ALU_SRL: alu_res = a >> opnd2[4:0];
            default: alu_res = '0;
        endcase
    end

    always_comb begin
        case (cur_reg.cond)
            BR_EQ:     taken = (a == b);
            BR_NE:     taken = (a != b);
            BR_LT:     taken = ($signed(a) < $signed(b));
            BR_GE:     taken = !($signed(a) < $signed(b));
            BR_LE:     taken = !($signed(b) < $signed(a));
            BR_ALWAYS: taken = 1'b1;
            default:   taken = 1'b0;
        endcase
    end

    // result of the item in flight
    always_comb begin
        logic jump_tgt;
        jump_tgt = 1'b0;
        res_npc  = pc_inc;
        res_wr   = 1'b0;
        res_val  = '0;
        res_err  = 1'b0;
        res_halt = halt_reg;
        if (state_reg == BK_LOAD) begin
            res_val = mem_rdata_reg;
            res_wr  = 1'b1;
        end else if (halt_reg) begin
            res_npc = pc_reg;
        end else begin
            case (cur_reg.cls)
                CLS_ALU: begin
                    res_val = alu_res;
                    res_wr  = 1'b1;
                end
                CLS_JALR: begin
                    res_val = link;
                    res_wr  = 1'b1;
                    res_npc = ld_addr[PC_W-1:0];
                end
                CLS_BRANCH: jump_tgt = taken;
                CLS_JAL: begin
                    res_val = link;
                    res_wr  = 1'b1;
                    if (cur_reg.rel) begin
                        res_npc = rel_tgt[PC_W-1:0];
                    end else begin
                        jump_tgt = 1'b1;
                    end
                end
                CLS_LI: begin
                    res_val = cur_reg.imm;
                    res_wr  = 1'b1;
                end
                CLS_LOAD:  res_err = addr_oob;  // in-range loads finish in BK_LOAD
                CLS_STORE: res_err = addr_oob;
                CLS_EXIT: begin
                    res_halt = 1'b1;
                    res_npc  = pc_reg;
                end
                default: ;
            endcase
            if (jump_tgt) begin
                if (cur_reg.known) begin
                    res_npc = PC_W'(XLEN'(cur_reg.tgt));
                end else begin
                    res_err = 1'b1;
                end
            end
            if (res_err) begin
                res_wr  = 1'b0;
                res_npc = pc_reg;
            end
        end
        if (cur_reg.rd == '0) begin
            res_wr = 1'b0;
        end
        if (!res_wr) begin
            res_val = '0;
        end
    end

    // FSM outputs
    always_comb begin
        q_pop     = 1'b0;
        finish    = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        clear_wr  = 1'b0;
        case (state_reg)
            BK_CLEAR: clear_wr = 1'b1;
            BK_READ:  q_pop = !q_empty;
            BK_EXEC: begin
                if (!halt_reg && cur_reg.cls == CLS_LOAD && !addr_oob) begin
                    mem_rd_en = 1'b1;
                end else begin
                    finish    = out_free;
                    mem_wr_en = out_free && !halt_reg && cur_reg.cls == CLS_STORE && !addr_oob;
                end
            end
            BK_LOAD:  finish = out_free;
            default: ;
        endcase
    end

    // FSM next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: if (clear_last) state_next = BK_READ;
            BK_READ:  if (!q_empty) state_next = BK_EXEC;
            BK_EXEC: begin
                if (mem_rd_en) begin
                    state_next = BK_LOAD;
                end else if (finish) begin
                    state_next = BK_READ;
                end
            end
            BK_LOAD:  if (finish) state_next = BK_READ;
            default:  state_next = BK_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            rf_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_wr) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (finish) begin
                pc_reg        <= res_npc;
                halt_reg      <= res_halt;
                out_valid_reg <= 1'b1;
                if (res_wr) begin
                    rf_vld_reg[cur_reg.rd] <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg      <= head_item;
            rf_a_reg     <= rf_mem[head_item.rs1];
            rf_b_reg     <= rf_mem[head_item.rs2];
            rf_a_vld_reg <= rf_vld_reg[head_item.rs1];
            rf_b_vld_reg <= rf_vld_reg[head_item.rs2];
        end
        if (finish && res_wr) begin
            rf_mem[cur_reg.rd] <= res_val;
        end
        if (finish) begin
            out_npc_reg  <= NEXT_PC_W'(res_npc);
            out_wr_reg   <= res_wr;
            out_rd_reg   <= res_wr ? cur_reg.rd : '0;
            out_val_reg  <= res_val;
            out_err_reg  <= res_err;
            out_halt_reg <= res_halt;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_wr) begin
            dmem[clr_idx_reg] <= '0;
        end else if (mem_wr_en) begin
            dmem[mem_addr[DA_W-1:0]] <= a;
        end
        if (mem_rd_en) begin
            mem_rdata_reg <= dmem[mem_addr[DA_W-1:0]];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_next_pc       = out_npc_reg;
    assign m_reg_written   = out_wr_reg;
    assign m_written_reg   = out_rd_reg;
    assign m_written_value = $signed(out_val_reg);
    assign m_error         = out_err_reg;
    assign m_halted        = out_halt_reg;

    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_wr_reg) |-> (out_rd_reg != '0))
        else $error("result reports a write to x0");

    a_err_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_err_reg) |-> (!out_wr_reg && !out_halt_reg))
        else $error("faulting item wrote a register or halted");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag dropped");

    a_no_pop_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> (!q_pop && !finish))
        else $error("item executed during memory clear");

endmodule

FILE: rtl/rv32_subset_execute_unit_top.sv
// Top level of the RV32 subset execute unit: front decode, item queue, back execute.
// Depends on rvx_pkg, rvx_front, rvx_queue, rvx_back.
//
// Executes one decoded RV32I-style instruction per input item against a
// 32-entry register file, a word-indexed data memory and a program counter,
// and returns one result item per input item (next pc, register write, error,
// halt). Both channels are valid/ready. After reset the back end sweeps the
// data memory to zero, one word per cycle; s_ready stays low until all
// DATA_DEPTH (1024) words are cleared, before the first item is taken. The
// front end decodes each item into an operation class and pushes it into a
// two-entry queue, so it keeps accepting items while the queue is not full,
// also while the back end is busy or a result waits on m_ready. The back
// end steps through register file read (BK_READ), then execute and write
// back (BK_EXEC); word loads add BK_LOAD for the registered data memory
// read. It takes no new item until the current one finishes, so throughput
// is set by the register file read followed by the execute step. Results
// leave through an output register; a result that is not taken holds the
// back end once its next item is ready to finish. Once exit has run, later
// items are consumed without effect and report the frozen pc with halted set.
module rv32_subset_execute_unit_top (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [4:0]          s_kind,
    input  logic [4:0]          s_dest_reg,
    input  logic [4:0]          s_src1_reg,
    input  logic [4:0]          s_src2_reg,
    input  logic signed [31:0]  s_immediate,
    input  logic [9:0]          s_target_pc,
    input  logic                s_target_known,
    input  logic                s_jump_relative,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_next_pc,
    output logic                m_reg_written,
    output logic [4:0]          m_written_reg,
    output logic signed [31:0]  m_written_value,
    output logic                m_error,
    output logic                m_halted
);
    import rvx_pkg::*;

    rvx_item_t  push_item, head_item;
    logic       q_push, q_pop, q_full, q_empty, clearing;

    // decode; stalls on a full queue or during the memory clear
    rvx_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_dest_reg      (s_dest_reg),
        .s_src1_reg      (s_src1_reg),
        .s_src2_reg      (s_src2_reg),
        .s_immediate     (s_immediate),
        .s_target_pc     (s_target_pc),
        .s_target_known  (s_target_known),
        .s_jump_relative (s_jump_relative),
        .q_full          (q_full),
        .clearing        (clearing),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    // decouples decode from execute
    rvx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // architectural state and execution
    rvx_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_item       (head_item),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .clearing        (clearing),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_pc       (m_next_pc),
        .m_reg_written   (m_reg_written),
        .m_written_reg   (m_written_reg),
        .m_written_value (m_written_value),
        .m_error         (m_error),
        .m_halted        (m_halted)
    );

endmodule
